@@ hw/rtl/tpx_pkg.sv @@
package tpx_pkg;

  // default sizes
  localparam int unsigned MaxFrameBytesDef = 65536;
  localparam int unsigned QueueDepthDef    = 4;

  // frame layout (byte offsets from the start of the ethernet header)
  localparam int unsigned EthHdrBytes  = 14;
  localparam int unsigned OffTypeHi    = 12;
  localparam int unsigned OffTypeLo    = 13;
  localparam int unsigned OffIhl       = 14;
  localparam int unsigned OffTotLenHi  = 16;
  localparam int unsigned OffTotLenLo  = 17;
  localparam int unsigned OffProto     = 23;
  localparam int unsigned OffSrcIpLo   = 26;
  localparam int unsigned OffSrcIpHi   = 29;
  localparam int unsigned OffDstIpLo   = 30;
  localparam int unsigned OffDstIpHi   = 33;
  localparam int unsigned OffTcpMin    = 34;

  // offsets inside the tcp header
  localparam int unsigned RelSrcPortHi = 0;
  localparam int unsigned RelSrcPortLo = 1;
  localparam int unsigned RelDstPortHi = 2;
  localparam int unsigned RelDstPortLo = 3;
  localparam int unsigned RelDataOff   = 12;

  // field values
  localparam logic [7:0]  EtherTypeHi  = 8'h08;
  localparam logic [7:0]  EtherTypeLo  = 8'h00;
  localparam logic [7:0]  IpProtoTcp   = 8'd6;
  localparam logic [3:0]  MinHdrWords  = 4'd5;
  localparam logic [15:0] MatchPortRst = 16'd25000;

  typedef enum logic {
    KIND_HEADER  = 1'b0,
    KIND_PAYLOAD = 1'b1
  } item_kind_e;

  // one result item
  typedef struct packed {
    item_kind_e  item_kind;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] segment_len;
    logic [7:0]  payload_byte;
    logic        last;
  } result_t;

endpackage

@@ hw/rtl/tcp_port_payload_extractor.sv @@
// a result item is written into the result queue and shows on the result ports once it reaches the head
// throughput: one frame byte per cycle, full only while QUEUE_DEPTH results wait unpopped
// the parser front end takes no frame byte while the result queue is full
// reset: asynchronous, active low; clears the frame parse, empties the queue
// and sets match_port to 25000
module tcp_port_payload_extractor #(
  parameter int unsigned MAX_FRAME_BYTES = tpx_pkg::MaxFrameBytesDef,
  parameter int unsigned QUEUE_DEPTH     = tpx_pkg::QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // frame byte input
  input  logic        push,
  output logic        full,
  input  logic [7:0]  frame_byte_i,
  input  logic        frame_end_i,
  // result output
  output logic        empty,
  input  logic        pop,
  output logic        item_kind_o,
  output logic [31:0] src_ip_o,
  output logic [31:0] dst_ip_o,
  output logic [15:0] src_port_o,
  output logic [15:0] dst_port_o,
  output logic [15:0] segment_len_o,
  output logic [7:0]  payload_byte_o,
  output logic        last_o,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] match_port_i
);
  import tpx_pkg::*;

  logic    in_acc;
  logic    res_valid;
  result_t res;
  result_t head;

  assign in_acc      = push && !full;
  assign cfg_ready_o = 1'b1;

  // front end: byte classification and header capture
  tpx_parser #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_acc_i    (in_acc),
    .frame_byte_i(frame_byte_i),
    .frame_end_i (frame_end_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .match_port_i(match_port_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // back end: result queue toward the consumer
  tpx_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_valid),
    .data_i (res),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (head)
  );

  assign item_kind_o    = head.item_kind;
  assign src_ip_o       = head.src_ip;
  assign dst_ip_o       = head.dst_ip;
  assign src_port_o     = head.src_port;
  assign dst_port_o     = head.dst_port;
  assign segment_len_o  = head.segment_len;
  assign payload_byte_o = head.payload_byte;
  assign last_o         = head.last;

endmodule

@@ hw/rtl/tpx_parser.sv @@
module tpx_parser #(
  parameter int unsigned MAX_FRAME_BYTES = 65536
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_acc_i,
  input  logic [7:0]       frame_byte_i,
  input  logic             frame_end_i,
  input  logic             cfg_we_i,
  input  logic [15:0]      match_port_i,
  output logic             res_valid_o,
  output tpx_pkg::result_t res_o
);
  import tpx_pkg::*;

  localparam int unsigned OffW = $clog2(MAX_FRAME_BYTES + 1);

  logic [15:0]     match_port_q;
  logic [OffW-1:0] off_q, off_d;
  logic            ok_q, ok_d;
  logic [5:0]      ip_hdr_q, ip_hdr_d;
  logic [5:0]      tcp_hdr_q, tcp_hdr_d;
  logic [15:0]     left_q, left_d;
  logic [15:0]     tot_len_q, tot_len_d;
  logic [31:0]     src_ip_q, src_ip_d;
  logic [31:0]     dst_ip_q, dst_ip_d;
  logic [15:0]     src_port_q, src_port_d;
  logic [15:0]     dst_port_q, dst_port_d;

  logic            in_range;
  logic [OffW-1:0] tcp_base;
  logic [OffW-1:0] rel;
  logic            tcp_zone;
  logic [3:0]      doff;
  logic [16:0]     seg;
  logic [15:0]     left_dec;

  // offset into the tcp header and header length arithmetic
  assign in_range = off_q < OffW'(MAX_FRAME_BYTES);
  assign tcp_base = OffW'(EthHdrBytes) + OffW'(ip_hdr_q);
  assign rel      = off_q - tcp_base;
  assign tcp_zone = ok_q && (off_q >= OffW'(OffTcpMin)) && (off_q >= tcp_base);
  assign doff     = frame_byte_i[7:4];
  assign seg      = {1'b0, tot_len_q} - {11'b0, ip_hdr_q} - {11'b0, doff, 2'b00};
  assign left_dec = left_q - 16'd1;

  // per byte classification
  always_comb begin
    off_d       = off_q;
    ok_d        = ok_q;
    ip_hdr_d    = ip_hdr_q;
    tcp_hdr_d   = tcp_hdr_q;
    left_d      = left_q;
    tot_len_d   = tot_len_q;
    src_ip_d    = src_ip_q;
    dst_ip_d    = dst_ip_q;
    src_port_d  = src_port_q;
    dst_port_d  = dst_port_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (in_acc_i && in_range) begin
      off_d = off_q + OffW'(1);
      if (ok_q) begin
        if (off_q == OffW'(OffTypeHi) && frame_byte_i != EtherTypeHi) ok_d = 1'b0;
        if (off_q == OffW'(OffTypeLo) && frame_byte_i != EtherTypeLo) ok_d = 1'b0;
        if (off_q == OffW'(OffIhl)) begin
          if (frame_byte_i[3:0] < MinHdrWords) ok_d = 1'b0;
          ip_hdr_d = {frame_byte_i[3:0], 2'b00};
        end
        if (off_q == OffW'(OffTotLenHi)) tot_len_d[15:8] = frame_byte_i;
        if (off_q == OffW'(OffTotLenLo)) tot_len_d[7:0] = frame_byte_i;
        if (off_q == OffW'(OffProto) && frame_byte_i != IpProtoTcp) ok_d = 1'b0;
        if (off_q >= OffW'(OffSrcIpLo) && off_q <= OffW'(OffSrcIpHi)) begin
          src_ip_d = {src_ip_q[23:0], frame_byte_i};
        end
        if (off_q >= OffW'(OffDstIpLo) && off_q <= OffW'(OffDstIpHi)) begin
          dst_ip_d = {dst_ip_q[23:0], frame_byte_i};
        end

        // tcp header and payload
        if (tcp_zone) begin
          if (rel == OffW'(RelSrcPortHi)) src_port_d[15:8] = frame_byte_i;
          if (rel == OffW'(RelSrcPortLo)) src_port_d[7:0] = frame_byte_i;
          if (rel == OffW'(RelDstPortHi)) dst_port_d[15:8] = frame_byte_i;
          if (rel == OffW'(RelDstPortLo)) begin
            dst_port_d[7:0] = frame_byte_i;
            if (src_port_q != match_port_q && dst_port_d != match_port_q) ok_d = 1'b0;
          end
          if (rel == OffW'(RelDataOff)) begin
            if (doff < MinHdrWords) begin
              ok_d = 1'b0;
            end else begin
              tcp_hdr_d = {doff, 2'b00};
              if (seg[16]) begin
                ok_d = 1'b0;
              end else begin
                left_d            = seg[15:0];
                res_valid_o       = 1'b1;
                res_o.item_kind   = KIND_HEADER;
                res_o.src_ip      = src_ip_q;
                res_o.dst_ip      = dst_ip_q;
                res_o.src_port    = src_port_q;
                res_o.dst_port    = dst_port_q;
                res_o.segment_len = seg[15:0];
                res_o.last        = (seg[15:0] == 16'd0) || frame_end_i;
              end
            end
          end else if (rel > OffW'(RelDataOff) && left_q != 16'd0 &&
                       rel >= OffW'(tcp_hdr_q)) begin
            left_d             = left_dec;
            res_valid_o        = 1'b1;
            res_o.item_kind    = KIND_PAYLOAD;
            res_o.payload_byte = frame_byte_i;
            res_o.last         = (left_dec == 16'd0) || frame_end_i;
          end
        end
      end
    end

    // end of frame restarts the parse
    if (in_acc_i && frame_end_i) begin
      off_d     = '0;
      ok_d      = 1'b1;
      ip_hdr_d  = '0;
      tcp_hdr_d = '0;
      left_d    = '0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_port_q <= MatchPortRst;
      off_q        <= '0;
      ok_q         <= 1'b1;
      ip_hdr_q     <= '0;
      tcp_hdr_q    <= '0;
      left_q       <= '0;
    end else begin
      if (cfg_we_i) match_port_q <= match_port_i;
      off_q     <= off_d;
      ok_q      <= ok_d;
      ip_hdr_q  <= ip_hdr_d;
      tcp_hdr_q <= tcp_hdr_d;
      left_q    <= left_d;
    end
  end

  // captured header fields, always rewritten before use
  always_ff @(posedge clk_i) begin
    tot_len_q  <= tot_len_d;
    src_ip_q   <= src_ip_d;
    dst_ip_q   <= dst_ip_d;
    src_port_q <= src_port_d;
    dst_port_q <= dst_port_d;
  end

`ifndef SYNTH
  a_end_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc_i && frame_end_i |=> off_q == '0 && ok_q && left_q == '0)
    else $error("frame end did not restart the parse");
  a_payload_needs_budget: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.item_kind == KIND_PAYLOAD |-> left_q != 16'd0)
    else $error("payload item with no payload left");
  a_result_only_on_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> in_acc_i && ok_q)
    else $error("result without an accepted byte of a good frame");
`endif

endmodule

@@ hw/rtl/tpx_queue.sv @@
module tpx_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  tpx_pkg::result_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output tpx_pkg::result_t data_o
);
  import tpx_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  result_t         entry_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == CntW'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entry_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_ptr_q] <= data_i;
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("queue count out of range");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("item pushed into a full queue");
  a_cnt_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && !do_pop |=> cnt_q == $past(cnt_q) + CntW'(1))
    else $error("queue count lost a push");
`endif

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps

module tb;

  import tpx_pkg::*;

  localparam int unsigned MaxBytes    = MaxFrameBytesDef;
  localparam int          DrainCycles = 8;
  localparam int          IdlePct     = 22;

  typedef enum logic [1:0] {
    ACT_BYTE,
    ACT_CFG,
    ACT_SYNC
  } plan_act_e;

  // one entry of the sender plan: a frame byte, a port write, or a pause
  typedef struct packed {
    plan_act_e   act;
    logic [7:0]  data;
    logic        fend;
    logic [15:0] port;
  } plan_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        push         = 1'b0;
  logic        full;
  logic [7:0]  frame_byte_i = '0;
  logic        frame_end_i  = 1'b0;
  logic        empty;
  logic        pop          = 1'b0;
  logic        item_kind_o;
  logic [31:0] src_ip_o;
  logic [31:0] dst_ip_o;
  logic [15:0] src_port_o;
  logic [15:0] dst_port_o;
  logic [15:0] segment_len_o;
  logic [7:0]  payload_byte_o;
  logic        last_o;
  logic        cfg_valid_i  = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] match_port_i = '0;

  plan_t   tx_plan[$];
  result_t parsed_results[$];
  result_t want_r;
  int      byte_cnt     = 0;
  int      mismatch_cnt = 0;
  int      quiet_cycles = 0;
  int      cyc          = 0;
  logic    calm;

  // driver next values
  logic        nx_push;
  logic        nx_cfg;
  logic [7:0]  nx_byte;
  logic        nx_end;
  logic [15:0] nx_port;

  // parser copy
  logic [15:0] port_cfg = MatchPortRst;
  logic [16:0] p_off;
  logic [5:0]  p_ihl_bytes;
  logic [5:0]  p_tcp_bytes;
  logic [15:0] p_tot;
  logic [31:0] p_sip;
  logic [31:0] p_dip;
  logic [15:0] p_sport;
  logic [15:0] p_dport;
  logic        p_ok;
  logic [15:0] p_left;

  tcp_port_payload_extractor u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .frame_byte_i  (frame_byte_i),
    .frame_end_i   (frame_end_i),
    .empty         (empty),
    .pop           (pop),
    .item_kind_o   (item_kind_o),
    .src_ip_o      (src_ip_o),
    .dst_ip_o      (dst_ip_o),
    .src_port_o    (src_port_o),
    .dst_port_o    (dst_port_o),
    .segment_len_o (segment_len_o),
    .payload_byte_o(payload_byte_o),
    .last_o        (last_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .match_port_i  (match_port_i)
  );

  // clock and cycle count
  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
  end

  // recurring stretch with no idling on either side
  assign calm = (cyc % 4096) >= 3000;

  // frame state back to the start of a frame
  task automatic clear_parse();
    p_off       = '0;
    p_ihl_bytes = '0;
    p_tcp_bytes = '0;
    p_tot       = '0;
    p_sip       = '0;
    p_dip       = '0;
    p_sport     = '0;
    p_dport     = '0;
    p_ok        = 1'b1;
    p_left      = '0;
  endtask

  // parse one accepted frame byte, queue the result item it causes
  task automatic parse_frame_byte(input logic [7:0] b, input logic fend);
    int      off;
    int      rel;
    int      seg;
    bit      hit;
    result_t r;
    hit = 1'b0;
    r   = '0;
    if (p_off < MaxBytes) begin
      off = int'(p_off);
      if (p_ok) begin
        if (off == OffTypeHi && b != EtherTypeHi) p_ok = 1'b0;
        if (off == OffTypeLo && b != EtherTypeLo) p_ok = 1'b0;
        if (off == OffIhl) begin
          if (b[3:0] < MinHdrWords) p_ok = 1'b0;
          p_ihl_bytes = {b[3:0], 2'b00};
        end
        if (off == OffTotLenHi) p_tot[15:8] = b;
        if (off == OffTotLenLo) p_tot[7:0] = b;
        if (off == OffProto && b != IpProtoTcp) p_ok = 1'b0;
        if (off >= OffSrcIpLo && off <= OffSrcIpHi) p_sip = {p_sip[23:0], b};
        if (off >= OffDstIpLo && off <= OffDstIpHi) p_dip = {p_dip[23:0], b};
        // tcp header and payload
        if (p_ok && off >= OffTcpMin && off >= EthHdrBytes + p_ihl_bytes) begin
          rel = off - EthHdrBytes - p_ihl_bytes;
          if (rel == RelSrcPortHi) p_sport[15:8] = b;
          if (rel == RelSrcPortLo) p_sport[7:0] = b;
          if (rel == RelDstPortHi) p_dport[15:8] = b;
          if (rel == RelDstPortLo) begin
            p_dport[7:0] = b;
            if (p_sport != port_cfg && p_dport != port_cfg) p_ok = 1'b0;
          end
          if (rel == RelDataOff) begin
            if (b[7:4] < MinHdrWords) begin
              p_ok = 1'b0;
            end else begin
              p_tcp_bytes = {b[7:4], 2'b00};
              seg = int'(p_tot) - int'(p_ihl_bytes) - int'(p_tcp_bytes);
              if (seg < 0) begin
                p_ok = 1'b0;
              end else begin
                p_left        = seg[15:0];
                r.item_kind   = KIND_HEADER;
                r.src_ip      = p_sip;
                r.dst_ip      = p_dip;
                r.src_port    = p_sport;
                r.dst_port    = p_dport;
                r.segment_len = seg[15:0];
                r.last        = (seg == 0) || fend;
                hit           = 1'b1;
              end
            end
          end else if (rel > RelDataOff && p_left != 0 && rel >= p_tcp_bytes) begin
            p_left         = p_left - 16'd1;
            r.item_kind    = KIND_PAYLOAD;
            r.payload_byte = b;
            r.last         = (p_left == 0) || fend;
            hit            = 1'b1;
          end
        end
      end
      p_off = 17'(off + 1);
    end
    if (fend) clear_parse();
    if (hit) parsed_results.push_back(r);
  endtask

  // sender plan builders
  task automatic add_byte(input logic [7:0] b, input logic fend);
    plan_t p;
    p      = '0;
    p.act  = ACT_BYTE;
    p.data = b;
    p.fend = fend;
    tx_plan.push_back(p);
    byte_cnt++;
  endtask

  task automatic add_cfg(input logic [15:0] port);
    plan_t p;
    p      = '0;
    p.act  = ACT_CFG;
    p.port = port;
    tx_plan.push_back(p);
  endtask

  task automatic add_sync();
    plan_t p;
    p     = '0;
    p.act = ACT_SYNC;
    tx_plan.push_back(p);
  endtask

  task automatic add_noise(input int n);
    for (int i = 0; i < n; i++) add_byte(8'($urandom_range(0, 255)), i == n - 1);
  endtask

  // build one frame; keep > 0 cuts it short, len_adj skews the ip total length
  task automatic add_frame(input logic [7:0] type_hi, input logic [7:0] type_lo,
                           input logic [7:0] proto, input logic [3:0] ihl,
                           input logic [3:0] doff, input int pay_n,
                           input logic [15:0] sp, input logic [15:0] dp,
                           input int len_adj, input int keep, input int pad_n);
    logic [7:0]  fb[$];
    logic [3:0]  nib;
    logic [15:0] tot;
    int          sync_at;
    tot = 16'(4 * ihl + 4 * doff + pay_n + len_adj);
    // ethernet header
    for (int i = 0; i < 12; i++) fb.push_back(8'($urandom_range(0, 255)));
    fb.push_back(type_hi);
    fb.push_back(type_lo);
    // ip header, version and the rest left random
    nib = 4'($urandom);
    fb.push_back({nib, ihl});
    fb.push_back(8'($urandom_range(0, 255)));
    fb.push_back(tot[15:8]);
    fb.push_back(tot[7:0]);
    for (int i = 18; i < 23; i++) fb.push_back(8'($urandom_range(0, 255)));
    fb.push_back(proto);
    for (int i = 24; i < 34; i++) fb.push_back(8'($urandom_range(0, 255)));
    for (int i = 20; i < 4 * ihl; i++) fb.push_back(8'($urandom_range(0, 255)));
    // tcp header
    fb.push_back(sp[15:8]);
    fb.push_back(sp[7:0]);
    fb.push_back(dp[15:8]);
    fb.push_back(dp[7:0]);
    for (int i = 4; i < 12; i++) fb.push_back(8'($urandom_range(0, 255)));
    nib = 4'($urandom);
    fb.push_back({doff, nib});
    for (int i = 13; i < 20 || i < 4 * doff; i++) fb.push_back(8'($urandom_range(0, 255)));
    // payload and trailing pad
    for (int i = 0; i < pay_n + pad_n; i++) fb.push_back(8'($urandom_range(0, 255)));
    if (keep > 0) begin
      while (fb.size() > keep) fb.pop_back();
    end
    // now and then the sender waits for the parser to drain mid frame
    sync_at = ($urandom_range(0, 19) == 0) ? $urandom_range(0, fb.size() - 1) : -1;
    for (int i = 0; i < fb.size(); i++) begin
      if (i == sync_at) add_sync();
      add_byte(fb[i], i == fb.size() - 1);
    end
  endtask

  // mostly well-formed matching frames, the rest broken in one way or replaced by random noise
  task automatic add_random_frame(input logic [15:0] port);
    logic [15:0] sp;
    logic [15:0] dp;
    logic [3:0]  ihl;
    logic [3:0]  doff;
    logic [7:0]  th;
    logic [7:0]  tl;
    logic [7:0]  pr;
    int          pay_n;
    int          pick;
    int          keep;
    int          adj;
    int          pad_n;
    sp = 16'($urandom);
    dp = 16'($urandom);
    if ($urandom_range(0, 1)) sp = port;
    else dp = port;
    if ($urandom_range(0, 9) == 0) begin
      sp = port;
      dp = port;
    end
    ihl   = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
    doff  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
    pay_n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 40);
    pad_n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
    th    = EtherTypeHi;
    tl    = EtherTypeLo;
    pr    = IpProtoTcp;
    keep  = 0;
    adj   = 0;
    pick  = $urandom_range(0, 99);
    if (pick < 75) begin
    end else if (pick < 79) begin
      sp = 16'($urandom);
      dp = 16'($urandom);
    end else if (pick < 82) begin
      th = 8'($urandom);
    end else if (pick < 85) begin
      tl = 8'($urandom);
    end else if (pick < 88) begin
      pr = 8'($urandom);
    end else if (pick < 90) begin
      ihl = 4'($urandom_range(0, 4));
    end else if (pick < 92) begin
      doff = 4'($urandom_range(0, 4));
    end else if (pick < 94) begin
      adj = -(pay_n + $urandom_range(1, 40));
    end else if (pick < 98) begin
      keep = $urandom_range(1, 14 + 4 * ihl + 4 * doff + pay_n);
    end else begin
      add_noise($urandom_range(1, 80));
      return;
    end
    add_frame(th, tl, pr, ihl, doff, pay_n, sp, dp, adj, keep, pad_n);
  endtask

  // driver: frame bytes and port writes from the plan, with random idling
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push         <= 1'b0;
      cfg_valid_i  <= 1'b0;
      quiet_cycles = 0;
      port_cfg     = MatchPortRst;
      clear_parse();
    end else begin
      nx_push = push;
      nx_cfg  = cfg_valid_i;
      nx_byte = frame_byte_i;
      nx_end  = frame_end_i;
      nx_port = match_port_i;
      // accepted byte goes through the parser copy
      if (push && !full) begin
        parse_frame_byte(frame_byte_i, frame_end_i);
        nx_push = 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        port_cfg = match_port_i;
        nx_cfg   = 1'b0;
      end
      // quiet time before a port write
      if (parsed_results.size() != 0 || push) quiet_cycles = 0;
      else if (quiet_cycles < 1000) quiet_cycles++;
      // next plan entry
      if (!nx_push && !nx_cfg && tx_plan.size() != 0 &&
          (calm || $urandom_range(0, 99) >= IdlePct)) begin
        case (tx_plan[0].act)
          ACT_BYTE: begin
            nx_push = 1'b1;
            nx_byte = tx_plan[0].data;
            nx_end  = tx_plan[0].fend;
            tx_plan.delete(0);
          end
          ACT_CFG: begin
            if (parsed_results.size() == 0 && quiet_cycles >= DrainCycles) begin
              nx_cfg  = 1'b1;
              nx_port = tx_plan[0].port;
              tx_plan.delete(0);
            end
          end
          default: begin
            if (parsed_results.size() == 0) tx_plan.delete(0);
          end
        endcase
      end
      push         <= nx_push;
      cfg_valid_i  <= nx_cfg;
      frame_byte_i <= nx_byte;
      frame_end_i  <= nx_end;
      match_port_i <= nx_port;
    end
  end

  task automatic cmp_field(input string name, input logic [31:0] want,
                           input logic [31:0] got);
    if (got !== want) begin
      mismatch_cnt++;
      $display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
    end
  endtask

  // monitor: check each popped result item against the oldest parsed one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (parsed_results.size() == 0) begin
          mismatch_cnt++;
          $display("%0t unexpected item: expected none actual kind %0d byte %h last %0d",
                   $time, item_kind_o, payload_byte_o, last_o);
        end else begin
          want_r = parsed_results.pop_front();
          cmp_field("item_kind", 32'(want_r.item_kind), 32'(item_kind_o));
          cmp_field("src_ip", want_r.src_ip, src_ip_o);
          cmp_field("dst_ip", want_r.dst_ip, dst_ip_o);
          cmp_field("src_port", 32'(want_r.src_port), 32'(src_port_o));
          cmp_field("dst_port", 32'(want_r.dst_port), 32'(dst_port_o));
          cmp_field("segment_len", 32'(want_r.segment_len), 32'(segment_len_o));
          cmp_field("payload_byte", 32'(want_r.payload_byte), 32'(payload_byte_o));
          cmp_field("last", 32'(want_r.last), 32'(last_o));
        end
      end
      pop <= calm || ($urandom_range(0, 99) >= IdlePct);
    end
  end

  // stimulus plan, reset and end of run
  initial begin : stimulus
    logic [15:0] port;
    int          stop_at;
    // reset port value
    add_frame(EtherTypeHi, EtherTypeLo, IpProtoTcp, 4'd5, 4'd5, 4, 16'd1234, MatchPortRst,
              0, 0, 0);
    add_frame(EtherTypeHi, EtherTypeLo, IpProtoTcp, 4'd15, 4'd15, 3, MatchPortRst, 16'd80,
              0, 0, 6);
    // port mismatch, bad ethertype, wrong protocol
    add_frame(EtherTypeHi, EtherTypeLo, IpProtoTcp, 4'd5, 4'd5, 4, 16'd1, 16'd2, 0, 0, 0);
    add_frame(8'h86, EtherTypeLo, IpProtoTcp, 4'd5, 4'd5, 4, 16'd7, MatchPortRst, 0, 0, 0);
    add_frame(EtherTypeHi, 8'hDD, IpProtoTcp, 4'd5, 4'd5, 4, 16'd7, MatchPortRst, 0, 0, 0);
    add_frame(EtherTypeHi, EtherTypeLo, 8'd17, 4'd5, 4'd5, 4, 16'd7, MatchPortRst, 0, 0, 0);
    // bad header lengths
    add_frame(EtherTypeHi, EtherTypeLo, IpProtoTcp, 4'd4, 4'd5, 4, 16'd7, MatchPortRst,
              0, 0, 0);
    add_frame(EtherTypeHi, EtherTypeLo, IpProtoTcp, 4'd0, 4'd5, 4, 16'd7, MatchPortRst,
              0, 0, 0);
    add_frame(EtherTypeHi, EtherTypeLo, IpProtoTcp, 4'd5, 4'd4, 4, 16'd7, MatchPortRst,
              0, 0, 0);
    add_frame(EtherTypeHi, EtherTypeLo, IpProtoTcp, 4'd5, 4'd0, 4, 16'd7, MatchPortRst,
              0, 0, 0);
    // negative segment length, then an empty segment with trailing bytes
    add_frame(EtherTypeHi, EtherTypeLo, IpProtoTcp, 4'd5, 4'd5, 4, 16'd7, MatchPortRst,
              -5, 0, 0);
    add_frame(EtherTypeHi, EtherTypeLo, IpProtoTcp, 4'd5, 4'd5, 0, 16'd7, MatchPortRst,
              0, 0, 4);
    // early ends: before the header item, on the data offset byte,
    // between header and payload, inside the payload
    add_frame(EtherTypeHi, EtherTypeLo, IpProtoTcp, 4'd5, 4'd5, 4, 16'd7, MatchPortRst,
              0, 30, 0);
    add_frame(EtherTypeHi, EtherTypeLo, IpProtoTcp, 4'd5, 4'd5, 4, 16'd7, MatchPortRst,
              0, 47, 0);
    add_frame(EtherTypeHi, EtherTypeLo, IpProtoTcp, 4'd5, 4'd5, 4, 16'd7, MatchPortRst,
              0, 50, 0);
    add_frame(EtherTypeHi, EtherTypeLo, IpProtoTcp, 4'd5, 4'd5, 10, 16'd7, MatchPortRst,
              0, 59, 0);
    add_noise(1);
    add_sync();
    // port register extremes
    add_cfg(16'h0000);
    add_frame(EtherTypeHi, EtherTypeLo, IpProtoTcp, 4'd5, 4'd5, 5, 16'h0000, 16'hFFFF,
              0, 0, 0);
    add_frame(EtherTypeHi, EtherTypeLo, IpProtoTcp, 4'd5, 4'd5, 5, 16'd9, MatchPortRst,
              0, 0, 0);
    add_cfg(16'hFFFF);
    add_frame(EtherTypeHi, EtherTypeLo, IpProtoTcp, 4'd6, 4'd7, 5, 16'h0000, 16'hFFFF,
              0, 0, 2);

    // random phases, each under its own port setting
    stop_at = 2000;
    while (byte_cnt < stop_at) begin
      case ($urandom_range(0, 5))
        0:       port = 16'h0000;
        1:       port = 16'hFFFF;
        2:       port = MatchPortRst;
        default: port = 16'($urandom);
      endcase
      add_cfg(port);
      repeat ($urandom_range(3, 10)) begin
        if ($urandom_range(0, 14) == 0) add_sync();
        add_random_frame(port);
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait for the plan and the parsed items to run out, then a short drain
    while (tx_plan.size() != 0 || push || cfg_valid_i || parsed_results.size() != 0)
      @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (mismatch_cnt == 0 && parsed_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
